// ===== hw/rtl/dqne_pkg.sv =====
package dqne_pkg;

   localparam int MAX_NAME = 256;
   localparam int NameLenW = $clog2(MAX_NAME);

   localparam int HeaderBytes = 12;
   localparam int FixedTail   = 4;
   localparam int QdCountHi   = 4;
   localparam int QdCountLo   = 5;

   localparam logic [7:0] CharDot  = 8'h2e;
   localparam logic [7:0] CharTerm = 8'h00;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] query_index;
      logic        name_end;
      logic [7:0]  name_char;
   } result_type;

endpackage

// ===== hw/rtl/dqne_parser.sv =====
module dqne_parser
   import dqne_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] msg_byte,
   input  logic       msg_last,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_LABEL,
      PH_SKIP,
      PH_DONE
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [3:0]           header_count_ff, header_count_in;
   logic [15:0]          questions_left_ff, questions_left_in;
   logic [15:0]          question_number_ff, question_number_in;
   logic [7:0]           label_left_ff, label_left_in;
   logic [NameLenW-1:0]  name_length_ff, name_length_in;
   logic                 first_label_ff, first_label_in;
   logic                 overflowed_ff, overflowed_in;
   logic [2:0]           skip_count_ff, skip_count_in;

   logic                 have;
   logic [7:0]           char_out;
   logic                 end_out;
   logic [1:0]           status_out;
   logic                 in_name;
   logic                 put_en;
   logic [7:0]           put_char;
   logic                 room;
   logic [7:0]           label_dec;

   assign room      = name_length_ff < NameLenW'(MAX_NAME - 1);
   assign label_dec = label_left_ff - 8'd1;

   always_comb begin
      phase_in           = phase_ff;
      header_count_in    = header_count_ff;
      questions_left_in  = questions_left_ff;
      question_number_in = question_number_ff;
      label_left_in      = label_left_ff;
      name_length_in     = name_length_ff;
      first_label_in     = first_label_ff;
      overflowed_in      = overflowed_ff;
      skip_count_in      = skip_count_ff;
      have       = 1'b0;
      char_out   = CharTerm;
      end_out    = 1'b0;
      status_out = STATUS_OK;
      in_name    = 1'b0;
      put_en     = 1'b0;
      put_char   = msg_byte;

      case (phase_ff)
         PH_HEADER: begin
            if (header_count_ff == 4'(QdCountHi)) begin
               questions_left_in = {msg_byte, 8'h00};
            end else if (header_count_ff == 4'(QdCountLo)) begin
               questions_left_in = {questions_left_ff[15:8], msg_byte};
            end
            header_count_in = header_count_ff + 4'd1;
            if (header_count_ff == 4'(HeaderBytes - 1)) begin
               header_count_in = '0;
               if (questions_left_ff == 16'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in       = PH_LENGTH;
                  name_length_in = '0;
                  first_label_in = 1'b1;
                  overflowed_in  = 1'b0;
                  label_left_in  = '0;
               end
            end
         end
         PH_LENGTH: begin
            if (msg_byte == 8'd0) begin
               have               = 1'b1;
               end_out            = 1'b1;
               status_out         = overflowed_ff ? STATUS_TOO_LONG : STATUS_OK;
               question_number_in = question_number_ff + 16'd1;
               questions_left_in  = questions_left_ff - 16'd1;
               skip_count_in      = '0;
               phase_in           = PH_SKIP;
            end else begin
               in_name        = 1'b1;
               label_left_in  = msg_byte;
               put_en         = !first_label_ff;
               put_char       = CharDot;
               first_label_in = 1'b0;
               phase_in       = PH_LABEL;
            end
         end
         PH_LABEL: begin
            in_name       = 1'b1;
            put_en        = 1'b1;
            label_left_in = label_dec;
            if (label_dec == 8'd0) begin
               phase_in = PH_LENGTH;
            end
         end
         PH_SKIP: begin
            skip_count_in = skip_count_ff + 3'd1;
            if (skip_count_ff == 3'(FixedTail - 1)) begin
               skip_count_in = '0;
               if (questions_left_ff == 16'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in       = PH_LENGTH;
                  name_length_in = '0;
                  first_label_in = 1'b1;
                  overflowed_in  = 1'b0;
                  label_left_in  = '0;
               end
            end
         end
         default: begin
         end
      endcase

      if (put_en) begin
         if (room) begin
            have           = 1'b1;
            char_out       = put_char;
            name_length_in = name_length_ff + NameLenW'(1);
         end else begin
            overflowed_in = 1'b1;
         end
      end

      // final byte: flag truncation inside a name, then back to reset state
      if (msg_last) begin
         if (in_name) begin
            have       = 1'b1;
            end_out    = 1'b1;
            status_out = STATUS_TRUNCATED;
         end
         phase_in           = PH_HEADER;
         header_count_in    = '0;
         questions_left_in  = '0;
         question_number_in = '0;
         label_left_in      = '0;
         name_length_in     = '0;
         first_label_in     = 1'b1;
         overflowed_in      = 1'b0;
         skip_count_in      = '0;
      end
   end

   assign res_valid       = byte_valid && have;
   assign res.name_char   = char_out;
   assign res.name_end    = end_out;
   assign res.query_index = question_number_ff;
   assign res.status      = status_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HEADER;
         header_count_ff    <= '0;
         questions_left_ff  <= '0;
         question_number_ff <= '0;
         label_left_ff      <= '0;
         name_length_ff     <= '0;
         first_label_ff     <= 1'b1;
         overflowed_ff      <= 1'b0;
         skip_count_ff      <= '0;
      end else if (byte_valid) begin
         phase_ff           <= phase_in;
         header_count_ff    <= header_count_in;
         questions_left_ff  <= questions_left_in;
         question_number_ff <= question_number_in;
         label_left_ff      <= label_left_in;
         name_length_ff     <= name_length_in;
         first_label_ff     <= first_label_in;
         overflowed_ff      <= overflowed_in;
         skip_count_ff      <= skip_count_in;
      end
   end

endmodule

// ===== hw/rtl/dqne_fifo.sv =====
module dqne_fifo
   import dqne_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop,
   output result_type pop_data,
   output logic       empty,
   output logic       full
);

   result_type          entry_ff [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FifoPtrW:0]   count_ff;
   logic                do_push, do_pop;

   assign empty    = count_ff == '0;
   assign full     = count_ff == (FifoPtrW+1)'(FifoDepth);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + FifoPtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FifoPtrW'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (FifoPtrW+1)'(1);
            2'b01:   count_ff <= count_ff - (FifoPtrW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== hw/rtl/dqne_out.sv =====
module dqne_out
   import dqne_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fifo_empty,
   input  result_type  fifo_data,
   output logic        fifo_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser
);

   logic       valid_ff;
   result_type data_ff;

   // refill the output register whenever it is empty or being drained
   assign fifo_pop = !fifo_empty && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || rsp_tready) begin
         valid_ff <= !fifo_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         data_ff <= fifo_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.query_index, data_ff.name_char};
   assign rsp_tlast  = data_ff.name_end;
   assign rsp_tuser  = data_ff.status;

endmodule

// ===== hw/rtl/dns_query_name_extractor.sv =====
// DNS query name extractor.
// The request channel carries a DNS message one byte per transfer, header
// first, with req_tlast on the final byte. The response channel carries the
// dotted name of each question one byte per transfer, closed by rsp_tlast
// on a zero byte, or on the cut byte when the message ends inside a name;
// rsp_tuser gives the status on that closing byte (ok, name too long,
// message truncated) and is zero elsewhere. Throughput is one byte per cycle
// while the queue has room: the parser updates its state in a single step
// for each accepted byte. Results pass through the queue and output register.
// A four-entry queue sits between the parser and the output register, so
// the parser keeps taking bytes while the receiver stalls; req_tready drops
// only once the queue is full, and resumes as rsp_tready drains it.
// Reset (synchronous, active high) empties the queue and the output
// register and puts the parser at the start of a message header. After
// the final byte of a message the parser returns to that same state by
// itself, so messages may follow back to back.
module dns_query_name_extractor
   import dqne_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // msg_byte[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // name_char[7:0], query_index[23:8]
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   logic       accept;
   logic       res_valid;
   result_type res;
   logic       fifo_pop;
   logic       fifo_empty;
   logic       fifo_full;
   result_type fifo_data;

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;

   dqne_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .msg_byte   (req_tdata),
      .msg_last   (req_tlast),
      .res_valid  (res_valid),
      .res        (res)
   );

   dqne_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (fifo_pop),
      .pop_data  (fifo_data),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   dqne_out u_out (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_data  (fifo_data),
      .fifo_pop   (fifo_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== dv/dns_query_name_extractor_tb.sv =====
module dns_query_name_extractor_tb;
   import dqne_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 360;
   localparam int QUIET_TAIL     = 150;
   localparam int LONG_HOLD      = 400;
   localparam int STALL_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 10;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       drain;   // not a byte: wait here until every name byte is back
   } stream_item_type;

   typedef enum logic [2:0] {
      P_HEADER, P_LENGTH, P_LABEL, P_TAIL, P_IGNORE
   } parse_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // msg_byte[7:0]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // name_char[7:0], query_index[23:8]
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;           // status[1:0]

   dns_query_name_extractor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_HALF) clock = ~clock;

   stream_item_type msg_stream[$];
   result_type      name_results[$];
   logic [7:0]      msg_buf[$];

   int error_count    = 0;
   int bytes_accepted = 0;
   int results_seen   = 0;
   int names_closed   = 0;
   int too_long_seen  = 0;
   int truncated_seen = 0;
   int messages_sent  = 0;
   int hold_at        = 0;
   int quiet_from     = 0;
   int idle_cycles    = 0;

   // parser copy
   parse_phase_type phase_q;
   int              hdr_pos;
   int              tail_pos;
   int              chars_out;
   logic [15:0]     qd_left;
   logic [15:0]     qd_num;
   logic [7:0]      label_left;
   logic            first_label;
   logic            name_overflow;

   function automatic void clear_parser();
      phase_q       = P_HEADER;
      hdr_pos       = 0;
      tail_pos      = 0;
      chars_out     = 0;
      qd_left       = '0;
      qd_num        = '0;
      label_left    = '0;
      first_label   = 1'b1;
      name_overflow = 1'b0;
   endfunction

   function automatic void open_name();
      phase_q       = P_LENGTH;
      chars_out     = 0;
      first_label   = 1'b1;
      name_overflow = 1'b0;
      label_left    = '0;
   endfunction

   function automatic logic room_for_char();
      if (chars_out < MAX_NAME - 1) begin
         chars_out++;
         return 1'b1;
      end
      name_overflow = 1'b1;
      return 1'b0;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic last_b);
      result_type r;
      logic       have;
      logic       in_name;
      r = '0;
      r.query_index = qd_num;
      have = 1'b0;
      in_name = 1'b0;
      case (phase_q)
         P_HEADER: begin
            if (hdr_pos == QdCountHi) qd_left = {b, 8'h00};
            else if (hdr_pos == QdCountLo) qd_left[7:0] = b;
            hdr_pos++;
            if (hdr_pos >= HeaderBytes) begin
               hdr_pos = 0;
               if (qd_left == 16'd0) phase_q = P_IGNORE;
               else open_name();
            end
         end
         P_LENGTH: begin
            if (b == 8'd0) begin
               have = 1'b1;
               r.name_char = CharTerm;
               r.name_end = 1'b1;
               r.status = name_overflow ? STATUS_TOO_LONG : STATUS_OK;
               qd_num++;
               qd_left--;
               tail_pos = 0;
               phase_q = P_TAIL;
            end else begin
               in_name = 1'b1;
               label_left = b;
               // a dot goes out on every length byte but the first, while there is room
               if (!first_label && room_for_char()) begin
                  have = 1'b1;
                  r.name_char = CharDot;
               end
               first_label = 1'b0;
               phase_q = P_LABEL;
            end
         end
         P_LABEL: begin
            in_name = 1'b1;
            if (room_for_char()) begin
               have = 1'b1;
               r.name_char = b;
            end
            label_left--;
            if (label_left == 8'd0) phase_q = P_LENGTH;
         end
         P_TAIL: begin
            tail_pos++;
            if (tail_pos >= FixedTail) begin
               tail_pos = 0;
               if (qd_left == 16'd0) phase_q = P_IGNORE;
               else open_name();
            end
         end
         default: ;
      endcase
      if (last_b) begin
         // message cut inside a name: the closing byte carries truncation
         if (in_name) begin
            if (!have) begin
               have = 1'b1;
               r.name_char = CharTerm;
            end
            r.name_end = 1'b1;
            r.status = STATUS_TRUNCATED;
         end
         clear_parser();
      end
      if (have) name_results.push_back(r);
   endfunction

   // message building
   task automatic start_msg(input logic [15:0] qd);
      msg_buf.delete();
      for (int i = 0; i < HeaderBytes; i++) begin
         if (i == QdCountHi) msg_buf.push_back(qd[15:8]);
         else if (i == QdCountLo) msg_buf.push_back(qd[7:0]);
         else msg_buf.push_back(8'($urandom));
      end
   endtask

   task automatic add_label(input int len);
      msg_buf.push_back(8'(len));
      repeat (len) msg_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic end_name();
      msg_buf.push_back(8'h00);
      repeat (FixedTail) msg_buf.push_back(8'($urandom));
   endtask

   task automatic add_name(input int nlabels, input int maxlen);
      repeat (nlabels) add_label($urandom_range(1, maxlen));
      end_name();
   endtask

   task automatic add_noise(input int n);
      repeat (n) msg_buf.push_back(8'($urandom));
   endtask

   // keep = 0 sends the whole message, otherwise only its first keep bytes, or all of it if it is shorter
   task automatic send_msg(input int keep);
      int n;
      n = (keep > 0 && keep < msg_buf.size()) ? keep : msg_buf.size();
      for (int i = 0; i < n; i++)
         msg_stream.push_back('{data: msg_buf[i], last: (i == n - 1), drain: 1'b0});
      messages_sent++;
   endtask

   task automatic add_drain();
      msg_stream.push_back('{data: 8'h00, last: 1'b0, drain: 1'b1});
   endtask

   task automatic fill_directed();
      // ends in the header
      start_msg(16'd3);
      send_msg(6);
      // no questions, bytes after the header ignored
      start_msg(16'd0);
      add_noise(5);
      send_msg(0);
      // root name only, then trailing bytes after the last question
      start_msg(16'd1);
      end_name();
      msg_buf.push_back(8'hff);
      msg_buf.push_back(8'h00);
      send_msg(0);
      // odd label bytes, then a single label of the largest length
      start_msg(16'd2);
      msg_buf.push_back(8'd1);
      msg_buf.push_back(8'hff);
      msg_buf.push_back(8'd1);
      msg_buf.push_back(8'h00);
      msg_buf.push_back(8'd1);
      msg_buf.push_back(CharDot);
      end_name();
      add_label(255);
      end_name();
      send_msg(0);
      // name past the length limit
      start_msg(16'd1);
      add_label(200);
      add_label(100);
      end_name();
      send_msg(0);
      // cut on a label character
      start_msg(16'd1);
      add_label(6);
      send_msg(15);
      // cut on a later length byte
      start_msg(16'd2);
      add_label(3);
      add_label(2);
      send_msg(17);
      // cut on the first length byte
      start_msg(16'd1);
      add_label(4);
      send_msg(13);
      // cut in the type and class bytes
      start_msg(16'd1);
      add_name(1, 5);
      send_msg(msg_buf.size() - 2);
      // full question count, cut after two names
      start_msg(16'hffff);
      add_name(2, 6);
      add_name(1, 3);
      add_label(5);
      send_msg(msg_buf.size() - 2);
      add_drain();
      // a run of root names under a large question count, ending in the tail bytes
      start_msg(16'h8001);
      repeat (24) end_name();
      send_msg(0);
      add_drain();
   endtask

   task automatic fill_random(input int target);
      int kind;
      int nq;
      int cut;
      logic [15:0] qd;
      while (msg_stream.size() < target) begin
         kind = $urandom_range(0, 9);
         nq = $urandom_range(1, 3);
         qd = (kind == 0) ? 16'd0 : (kind == 1) ? 16'($urandom) : 16'(nq);
         start_msg(qd);
         if (kind == 0) begin
            add_noise($urandom_range(1, 6));
         end else begin
            for (int q = 0; q < nq; q++)
               add_name($urandom_range(0, 3), ($urandom_range(0, 19) == 0) ? 120 : 8);
            if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 5));
         end
         cut = (kind == 2) ? $urandom_range(1, msg_buf.size()) : 0;
         send_msg(cut);
         if ($urandom_range(0, 9) == 0) add_drain();
      end
   endtask

   // sender
   int   send_gap = 0;
   logic send_idle_on = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         clear_parser();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            void'(msg_stream.pop_front());
            bytes_accepted++;
         end
         if ($urandom_range(0, 199) == 0) send_idle_on = !send_idle_on;
         if (!req_tvalid || req_tready) begin
            if (msg_stream.size() > 0 && msg_stream[0].drain && name_results.size() == 0)
               void'(msg_stream.pop_front());
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (msg_stream.size() == 0 || msg_stream[0].drain) begin
               req_tvalid <= 1'b0;
            end else if (send_idle_on && bytes_accepted < quiet_from
                         && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 7);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= msg_stream[0].data;
               req_tlast  <= msg_stream[0].last;
            end
         end
      end
   end

   // receiver
   int   recv_gap = 0;
   int   long_hold_left = 0;
   logic long_hold_done = 1'b0;
   logic recv_idle_on = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) recv_idle_on = !recv_idle_on;
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && bytes_accepted >= hold_at) begin
            // long stall so the output queue fills and the input backs up
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (recv_idle_on && bytes_accepted < quiet_from
                      && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker
   result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tlast) names_closed++;
         if (rsp_tuser == STATUS_TOO_LONG) too_long_seen++;
         if (rsp_tuser == STATUS_TRUNCATED) truncated_seen++;
         if (name_results.size() == 0) begin
            $error("unexpected transfer: name_char %h query_index %0d", rsp_tdata[7:0],
                   rsp_tdata[23:8]);
            error_count++;
         end else begin
            want = name_results.pop_front();
            if (rsp_tdata[7:0] !== want.name_char) begin
               $error("name_char: expected %h, got %h", want.name_char, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tlast !== want.name_end) begin
               $error("name_end: expected %b, got %b", want.name_end, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[23:8] !== want.query_index) begin
               $error("query_index: expected %0d, got %0d", want.query_index,
                      rsp_tdata[23:8]);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles, %0d name bytes still due", idle_cycles,
                  name_results.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_start;
      clear_parser();
      fill_directed();
      random_start = msg_stream.size();
      hold_at = random_start + 100;
      fill_random(random_start + RANDOM_ITEMS);
      add_drain();
      quiet_from = msg_stream.size() - QUIET_TAIL;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (msg_stream.size() > 0 || name_results.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d messages, %0d bytes in; %0d name bytes checked over %0d names",
               messages_sent, bytes_accepted, results_seen, names_closed);
      $display("overlong names %0d, truncated names %0d", too_long_seen, truncated_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
